@@ rtl/mbap_frame_deframer_top_defines.svh @@
// assertion macros for the bound checker module mbap_checker
`ifndef MBAP_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define MBAP_FRAME_DEFRAMER_TOP_DEFINES_SVH

// property checked only while out of reset
`define MBAP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define MBAP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mbap_pkg.sv @@
package mbap_pkg;

    localparam int HDR_LEN   = 6;
    localparam int MIN_LEN   = 2;
    localparam int BYTE_BITS = 8;
    localparam int MAX_FRAME = 260;
    localparam int LEN_W     = 9;
    localparam int QDEPTH    = 4;

    typedef struct packed {
        logic                 op;
        logic [BYTE_BITS-1:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic                 kind;
        logic [BYTE_BITS-1:0] frame_byte;
        logic                 first_of_frame;
        logic                 last_of_frame;
        logic [LEN_W-1:0]     frame_length;
    } t_out_item;

    // input op codes
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_ABORT = 1'b1;

    // output kind codes
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef enum logic [1:0] {
        CMD_ERR,
        CMD_HDR,
        CMD_BODY
    } t_cmd;

    // one queued job for the back end
    typedef struct packed {
        t_cmd                                cmd;
        logic [HDR_LEN-1:0][BYTE_BITS-1:0]   bytes;
        logic [LEN_W-1:0]                    total;
        logic                                last;
    } t_cmd_item;

endpackage

@@ rtl/mbap_front.sv @@
module mbap_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mbap_pkg::t_in_item  i_in_data,
    input  logic                i_q_full,
    output logic                o_q_push,
    output mbap_pkg::t_cmd_item o_q_item
);

    localparam int HDR_STORE = mbap_pkg::HDR_LEN - 1;
    localparam int LW        = mbap_pkg::LEN_W;
    localparam int BW        = mbap_pkg::BYTE_BITS;

    logic [BW-1:0] r_hdr [HDR_STORE];
    logic [LW-1:0] r_seen, n_seen;
    logic [LW-1:0] r_total, n_total;
    logic          hdr_we;
    logic          acc;
    logic [2*BW-1:0] len_field;
    logic [2*BW:0]   total_wide;
    logic [LW-1:0]   seen_inc;

    assign o_in_ready = !i_q_full;
    assign acc        = i_in_valid && o_in_ready;
    assign len_field  = {r_hdr[HDR_STORE-1], i_in_data.data_byte};
    assign total_wide = (2*BW+1)'(mbap_pkg::HDR_LEN) + (2*BW+1)'(len_field);
    assign seen_inc   = r_seen + LW'(1);

    always_comb begin
        n_seen   = r_seen;
        n_total  = r_total;
        hdr_we   = 1'b0;
        o_q_push = 1'b0;
        o_q_item.cmd   = mbap_pkg::CMD_BODY;
        o_q_item.bytes = '0;
        o_q_item.total = r_total;
        o_q_item.last  = 1'b0;
        if (acc) begin
            if (i_in_data.op == mbap_pkg::OP_ABORT) begin
                n_seen  = '0;
                n_total = '0;
            end else if (r_total == '0) begin
                if (r_seen < LW'(HDR_STORE)) begin
                    hdr_we = 1'b1;
                    n_seen = seen_inc;
                end else if (len_field < (2*BW)'(mbap_pkg::MIN_LEN) ||
                             total_wide > (2*BW+1)'(mbap_pkg::MAX_FRAME)) begin
                    // bad length field: drop header and hunt again
                    n_seen       = '0;
                    o_q_push     = 1'b1;
                    o_q_item.cmd = mbap_pkg::CMD_ERR;
                end else begin
                    n_total        = total_wide[LW-1:0];
                    n_seen         = LW'(mbap_pkg::HDR_LEN);
                    o_q_push       = 1'b1;
                    o_q_item.cmd   = mbap_pkg::CMD_HDR;
                    o_q_item.total = total_wide[LW-1:0];
                    o_q_item.bytes = {i_in_data.data_byte, r_hdr[4], r_hdr[3],
                                      r_hdr[2], r_hdr[1], r_hdr[0]};
                end
            end else begin
                o_q_push          = 1'b1;
                o_q_item.cmd      = mbap_pkg::CMD_BODY;
                o_q_item.bytes[0] = i_in_data.data_byte;
                o_q_item.last     = (seen_inc >= r_total);
                if (seen_inc >= r_total) begin
                    n_seen  = '0;
                    n_total = '0;
                end else begin
                    n_seen = seen_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_total <= '0;
        end else begin
            r_seen  <= n_seen;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[r_seen[2:0]] <= i_in_data.data_byte;
        end
    end

endmodule

@@ rtl/mbap_fifo.sv @@
module mbap_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mbap_pkg::t_cmd_item i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output mbap_pkg::t_cmd_item o_item
);

    localparam int DEPTH = mbap_pkg::QDEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    mbap_pkg::t_cmd_item r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ rtl/mbap_back.sv @@
module mbap_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  mbap_pkg::t_cmd_item i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mbap_pkg::t_out_item o_out_data
);

    logic [2:0]          r_idx, n_idx;
    logic                r_out_valid;
    mbap_pkg::t_out_item r_out, n_out;
    logic                load;

    // refill the output register when it is empty or being taken
    assign load        = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_idx   = r_idx;
        o_q_pop = 1'b0;
        n_out.kind           = mbap_pkg::KIND_FRAME;
        n_out.frame_byte     = i_q_item.bytes[0];
        n_out.first_of_frame = 1'b0;
        n_out.last_of_frame  = i_q_item.last;
        n_out.frame_length   = i_q_item.total;
        if (load) begin
            case (i_q_item.cmd)
                mbap_pkg::CMD_ERR: begin
                    n_out.kind          = mbap_pkg::KIND_ERROR;
                    n_out.frame_byte    = '0;
                    n_out.last_of_frame = 1'b1;
                    n_out.frame_length  = '0;
                    o_q_pop             = 1'b1;
                end
                mbap_pkg::CMD_HDR: begin
                    // header leaves one byte per cycle from the queued copy unless the output stalls
                    n_out.frame_byte     = i_q_item.bytes[r_idx];
                    n_out.first_of_frame = (r_idx == '0);
                    n_out.last_of_frame  = 1'b0;
                    if (r_idx == 3'(mbap_pkg::HDR_LEN - 1)) begin
                        n_idx   = '0;
                        o_q_pop = 1'b1;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
                default: begin
                    o_q_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

@@ rtl/mbap_frame_deframer_top.sv @@
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+---------------------------
// in       | input     | i_in_valid / o_in_ready  | i_in_data  (op, data_byte)
// out      | output    | o_out_valid / i_out_ready| o_out_data (kind .. length)
//
// input takes one item per cycle while the 4-entry job queue has room
// a good header leaves as six output items, one per cycle unless the sink stalls; body bytes and errors one each
// the output register holds one result; its sink sets the output rate
// synchronous active-low reset clears counters, queue pointers and output valid
// the held header bytes are not reset: each is written before it is read
module mbap_frame_deframer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mbap_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mbap_pkg::t_out_item o_out_data
);

    logic                q_push, q_full, q_pop, q_valid;
    mbap_pkg::t_cmd_item q_wr_item, q_rd_item;

    mbap_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_item   (q_wr_item)
    );

    mbap_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_wr_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_rd_item)
    );

    mbap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_rd_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ rtl/mbap_checker.sv @@
`include "mbap_frame_deframer_top_defines.svh"

module mbap_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input mbap_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mbap_pkg::t_out_item o_out_data
);

    logic stalled;
    logic out_err;
    logic out_frame;
    logic out_first;
    logic err_shape_ok;
    logic len_ok;
    logic first_ok;

    assign stalled   = o_out_valid && !i_out_ready;
    assign out_err   = o_out_valid && o_out_data.kind == mbap_pkg::KIND_ERROR;
    assign out_frame = o_out_valid && o_out_data.kind == mbap_pkg::KIND_FRAME;
    assign out_first = o_out_valid && o_out_data.first_of_frame;

    assign err_shape_ok = o_out_data.last_of_frame && !o_out_data.first_of_frame &&
                          o_out_data.frame_length == '0 && o_out_data.frame_byte == '0;
    assign len_ok       = o_out_data.frame_length >= 9'(mbap_pkg::HDR_LEN + mbap_pkg::MIN_LEN) &&
                          o_out_data.frame_length <= 9'(mbap_pkg::MAX_FRAME);
    assign first_ok     = o_out_data.kind == mbap_pkg::KIND_FRAME && !o_out_data.last_of_frame;

    // a stalled result holds
    `MBAP_ASSERT(a_out_hold, i_clk, i_rst_n, stalled |=> o_out_valid && $stable(o_out_data), "stall lost")

    // error results carry a fixed shape
    `MBAP_ASSERT(a_err_shape, i_clk, i_rst_n, out_err |-> err_shape_ok, "bad error result")

    // frame bytes belong to a frame of legal size
    `MBAP_ASSERT(a_frame_len, i_clk, i_rst_n, out_frame |-> len_ok, "frame length out of range")

    // a frame's first byte is never its last
    `MBAP_ASSERT(a_first_not_last, i_clk, i_rst_n, out_first |-> first_ok, "first byte marked last")

    // nothing shown right after reset
    `MBAP_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind mbap_frame_deframer_top mbap_checker u_mbap_checker (.*);

@@ tb/sv/mbap_deframe_checker.sv @@
`timescale 1ns / 100ps

module mbap_deframe_checker
    import mbap_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    logic [BYTE_BITS-1:0] hdr_hold [HDR_LEN-1];
    logic [LEN_W-1:0]     taken_cnt;
    logic [LEN_W-1:0]     parsed_total;
    t_out_item            frame_bytes_q[$];
    int                   fail_cnt;

    // works out the frame bytes or error that one accepted item releases
    task automatic predict_deframe(input t_in_item it);
        logic [15:0] len_field;
        int          total;
        t_out_item   res;
        if (it.op == OP_ABORT) begin
            taken_cnt    = '0;
            parsed_total = '0;
        end else if (parsed_total == 0) begin
            if (taken_cnt < HDR_LEN - 1) begin
                hdr_hold[taken_cnt] = it.data_byte;
                taken_cnt = taken_cnt + 1'b1;
            end else begin
                len_field = {hdr_hold[HDR_LEN-2], it.data_byte};
                total     = HDR_LEN + int'(len_field);
                if (len_field < MIN_LEN || total > MAX_FRAME) begin
                    taken_cnt         = '0;
                    res               = '0;
                    res.kind          = KIND_ERROR;
                    res.last_of_frame = 1'b1;
                    frame_bytes_q.push_back(res);
                end else begin
                    // whole header goes out at once
                    for (int k = 0; k < HDR_LEN; k++) begin
                        res.kind           = KIND_FRAME;
                        res.frame_byte     = (k < HDR_LEN - 1) ? hdr_hold[k] : it.data_byte;
                        res.first_of_frame = (k == 0);
                        res.last_of_frame  = (k + 1 == total);
                        res.frame_length   = total[LEN_W-1:0];
                        frame_bytes_q.push_back(res);
                    end
                    parsed_total = total[LEN_W-1:0];
                    taken_cnt    = HDR_LEN[LEN_W-1:0];
                    if (total == HDR_LEN) begin
                        taken_cnt    = '0;
                        parsed_total = '0;
                    end
                end
            end
        end else begin
            taken_cnt          = taken_cnt + 1'b1;
            res.kind           = KIND_FRAME;
            res.frame_byte     = it.data_byte;
            res.first_of_frame = 1'b0;
            res.last_of_frame  = (taken_cnt >= parsed_total);
            res.frame_length   = parsed_total;
            frame_bytes_q.push_back(res);
            if (res.last_of_frame) begin
                taken_cnt    = '0;
                parsed_total = '0;
            end
        end
    endtask

    initial begin
        fail_cnt     = 0;
        taken_cnt    = '0;
        parsed_total = '0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            frame_bytes_q.delete();
            taken_cnt    = '0;
            parsed_total = '0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_deframe(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (frame_bytes_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected item: kind=%0d byte=%02h first=%0d last=%0d len=%0d",
                             $time, i_out_data.kind, i_out_data.frame_byte,
                             i_out_data.first_of_frame, i_out_data.last_of_frame,
                             i_out_data.frame_length);
                end else begin
                    exp_item = frame_bytes_q.pop_front();
                    if (i_out_data.kind !== exp_item.kind
                        || i_out_data.frame_byte !== exp_item.frame_byte
                        || i_out_data.first_of_frame !== exp_item.first_of_frame
                        || i_out_data.last_of_frame !== exp_item.last_of_frame
                        || i_out_data.frame_length !== exp_item.frame_length) begin
                        fail_cnt++;
                        $display({"%0t: mismatch: expected kind=%0d byte=%02h first=%0d",
                                  " last=%0d len=%0d"},
                                 $time, exp_item.kind, exp_item.frame_byte,
                                 exp_item.first_of_frame, exp_item.last_of_frame,
                                 exp_item.frame_length);
                        $display({"%0t:           actual kind=%0d byte=%02h first=%0d",
                                  " last=%0d len=%0d"},
                                 $time, i_out_data.kind, i_out_data.frame_byte,
                                 i_out_data.first_of_frame, i_out_data.last_of_frame,
                                 i_out_data.frame_length);
                    end
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= frame_bytes_q.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import mbap_pkg::*;

    localparam int PHASE_ITEMS = 25;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    int        idle_pct  = 0;
    int        stall_pct = 0;
    int        sent_cnt  = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    mbap_frame_deframer_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    mbap_deframe_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // sink stalls at random
    always @(negedge clk) begin
        out_ready = (stall_pct == 0) || ($urandom_range(99, 0) >= stall_pct);
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic op, input logic [BYTE_BITS-1:0] b);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid          = 1'b1;
        in_data.op        = op;
        in_data.data_byte = b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent_cnt++;
    endtask

    // header with random transaction and protocol ids, then the body if the length is good;
    // abort_at >= 0 replaces the byte at that position with an abort
    task automatic send_frame(input logic [15:0] len_field, input int abort_at);
        int                   n_bytes;
        logic [BYTE_BITS-1:0] b;
        n_bytes = (len_field < MIN_LEN || HDR_LEN + int'(len_field) > MAX_FRAME)
                  ? HDR_LEN : HDR_LEN + int'(len_field);
        for (int i = 0; i < n_bytes; i++) begin
            if (i == HDR_LEN - 2) b = len_field[15:8];
            else if (i == HDR_LEN - 1) b = len_field[7:0];
            else b = 8'($urandom_range(255, 0));
            if (i == abort_at) begin
                send_byte(OP_ABORT, 8'($urandom_range(255, 0)));
                return;
            end
            send_byte(OP_DATA, b);
        end
    endtask

    task automatic send_random_traffic();
        int          r;
        int          len;
        logic [15:0] bad_len;
        r = int'($urandom_range(99, 0));
        if (r < 6) begin
            send_frame(16'($urandom_range(1, 0)), -1);
        end else if (r < 12) begin
            bad_len = ($urandom_range(3, 0) == 0) ? 16'd255 : 16'($urandom_range(65535, 256));
            send_frame(bad_len, -1);
        end else if (r < 20) begin
            len = int'($urandom_range(12, MIN_LEN));
            send_frame(16'(len), int'($urandom_range(HDR_LEN + len - 1, 0)));
        end else if (r < 26) begin
            // stray bytes, then a connection close to get back in step
            repeat ($urandom_range(4, 1)) send_byte(OP_DATA, 8'($urandom_range(255, 0)));
            send_byte(OP_ABORT, 8'($urandom_range(255, 0)));
        end else if (r < 34) begin
            send_frame(16'($urandom_range(40, 13)), -1);
        end else begin
            send_frame(16'($urandom_range(12, MIN_LEN)), -1);
        end
    endtask

    initial begin
        int phase_end;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: close with nothing held, shortest frame, bad lengths, close mid-header
        send_byte(OP_ABORT, 8'hFF);
        send_frame(16'd2, -1);
        send_frame(16'd0, -1);
        send_frame(16'hFFFF, -1);
        send_frame(16'd2, 3);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 65;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 65;
                end
                default: begin
                    idle_pct  = 37;
                    stall_pct = 37;
                end
            endcase
            if (phase == 0) begin
                send_frame(16'(MAX_FRAME - HDR_LEN), -1);
            end
            phase_end = sent_cnt + PHASE_ITEMS;
            while (sent_cnt < phase_end) send_random_traffic();
        end
        in_valid = 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
